FILE: rtl/olid_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Field widths, operation and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package olid_pkg;

   localparam int MODE_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 6;

   // Operation codes; any other code is a delete at position
   localparam logic [MODE_W-1:0] MODE_INS_FRONT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND    = 2'd1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_LIST
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic shift_rd;
      logic shift_wr;
      logic list_issue;
   } ctl_cmd_type;

   typedef struct packed {
      logic need_shift;
      logic shift_end;
      logic list_end;
      logic a_free;
   } dp_stat_type;

endpackage

FILE: rtl/olid_req_if.sv
// ----------------------------------------------------------------------------
// Ordered list request channel
// One operation per transaction: mode, value and position.
// ----------------------------------------------------------------------------
interface olid_req_if;
   logic                                valid;
   logic                                ready;
   logic [olid_pkg::MODE_W-1:0]         mode;
   logic signed [olid_pkg::VALUE_W-1:0] value;
   logic [olid_pkg::POS_W-1:0]          position;

   modport source (output valid, output mode, output value, output position, input ready);
   modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

FILE: rtl/olid_rsp_if.sv
// ----------------------------------------------------------------------------
// Ordered list response channel
// One listed element per transaction, last marks the end of a listing.
// ----------------------------------------------------------------------------
interface olid_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [olid_pkg::STATUS_W-1:0]        status;
   logic                                 list_empty;
   logic signed [olid_pkg::VALUE_W-1:0]  element_value;
   logic [olid_pkg::INDEX_W-1:0]         element_index;
   logic                                 last;

   modport source (output valid, output status, output list_empty, output element_value,
                   output element_index, output last, input ready);
   modport sink   (input valid, input status, input list_empty, input element_value,
                   input element_index, input last, output ready);
endinterface

FILE: rtl/olid_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered list controller
// Sequences capture, update, compaction after a delete and the listing reads.
// ----------------------------------------------------------------------------
module olid_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  olid_pkg::dp_stat_type stat,
   output olid_pkg::ctl_cmd_type cmd
);

   olid_pkg::state_type state_ff;
   olid_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= olid_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         olid_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = olid_pkg::S_UPDATE;
            end
         end
         olid_pkg::S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = stat.need_shift ? olid_pkg::S_SHIFT_RD : olid_pkg::S_LIST;
         end
         olid_pkg::S_SHIFT_RD: begin
            cmd.shift_rd = 1'b1;
            state_in     = olid_pkg::S_SHIFT_WR;
         end
         olid_pkg::S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = stat.shift_end ? olid_pkg::S_LIST : olid_pkg::S_SHIFT_RD;
         end
         olid_pkg::S_LIST: begin
            // issue one read whenever the first output stage can take it
            if (stat.a_free) begin
               cmd.list_issue = 1'b1;
               if (stat.list_end) begin
                  state_in = olid_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = olid_pkg::S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/olid_datapath.sv
// ----------------------------------------------------------------------------
// Ordered list datapath
// Circular element store with head pointer and length, delete compaction,
// and a two-stage read/output pipeline for the listing.
// ----------------------------------------------------------------------------
module olid_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  olid_pkg::ctl_cmd_type                cmd,
   output olid_pkg::dp_stat_type                stat,
   input  logic [olid_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [olid_pkg::VALUE_W-1:0]  req_value,
   input  logic [olid_pkg::POS_W-1:0]           req_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [olid_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_list_empty,
   output logic signed [olid_pkg::VALUE_W-1:0]  rsp_element_value,
   output logic [olid_pkg::INDEX_W-1:0]         rsp_element_index,
   output logic                                 rsp_last
);

   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int SUM_W = LEN_W + 1;

   // logical position to store address, wrapping once around the ring
   function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                             input logic [LEN_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return PTR_W'(sum);
   endfunction

   logic signed [olid_pkg::VALUE_W-1:0] mem [CAPACITY];

   logic [olid_pkg::MODE_W-1:0]         mode_ff;
   logic signed [olid_pkg::VALUE_W-1:0] value_ff;
   logic [olid_pkg::POS_W-1:0]          pos_ff;
   logic [PTR_W-1:0]                    head_ff, head_in;
   logic [LEN_W-1:0]                    len_ff, len_in;
   logic [LEN_W-1:0]                    cur_ff, cur_in;
   logic [olid_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic signed [olid_pkg::VALUE_W-1:0] shift_data_ff;

   logic                                a_valid_ff;
   logic signed [olid_pkg::VALUE_W-1:0] a_data_ff;
   logic [olid_pkg::INDEX_W-1:0]        a_index_ff;
   logic                                a_last_ff;
   logic                                a_empty_ff;
   logic [olid_pkg::STATUS_W-1:0]       a_status_ff;

   logic                                b_valid_ff;
   logic signed [olid_pkg::VALUE_W-1:0] b_value_ff;
   logic [olid_pkg::INDEX_W-1:0]        b_index_ff;
   logic                                b_last_ff;
   logic                                b_empty_ff;
   logic [olid_pkg::STATUS_W-1:0]       b_status_ff;

   logic [PTR_W-1:0]                    head_dec, head_inc;
   logic [LEN_W-1:0]                    len_dec, cur_p1;
   logic                                is_ins, full, range_err, at_back;
   logic                                mem_we;
   logic [PTR_W-1:0]                    mem_waddr, rd_addr;
   logic signed [olid_pkg::VALUE_W-1:0] mem_wdata;
   logic                                a_move;

   assign head_dec  = (head_ff == '0) ? PTR_W'(CAPACITY - 1) : head_ff - PTR_W'(1);
   assign head_inc  = (head_ff == PTR_W'(CAPACITY - 1)) ? '0 : head_ff + PTR_W'(1);
   assign len_dec   = len_ff - LEN_W'(1);
   assign cur_p1    = cur_ff + LEN_W'(1);
   assign is_ins    = (mode_ff == olid_pkg::MODE_INS_FRONT) || (mode_ff == olid_pkg::MODE_APPEND);
   assign full      = (len_ff == LEN_W'(CAPACITY));
   assign range_err = (pos_ff >= olid_pkg::POS_W'(len_ff));
   assign at_back   = (olid_pkg::POS_W'(len_dec) == pos_ff);
   assign rd_addr   = phys(head_ff, cmd.shift_rd ? cur_p1 : cur_ff);
   assign a_move    = a_valid_ff && (!b_valid_ff || rsp_ready);

   assign stat.need_shift = !is_ins && !range_err && (pos_ff != '0) && !at_back;
   assign stat.shift_end  = (cur_p1 == len_dec);
   assign stat.list_end   = (len_ff == '0) || (cur_p1 == len_ff);
   assign stat.a_free     = !a_valid_ff || a_move;

   always_comb begin
      head_in   = head_ff;
      len_in    = len_ff;
      cur_in    = cur_ff;
      status_in = status_ff;
      mem_we    = 1'b0;
      mem_waddr = phys(head_ff, len_ff);
      mem_wdata = value_ff;
      if (cmd.update) begin
         status_in = olid_pkg::ST_DONE;
         cur_in    = '0;
         case (mode_ff)
            olid_pkg::MODE_INS_FRONT: begin
               if (full) begin
                  status_in = olid_pkg::ST_FULL;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = head_dec;
                  head_in   = head_dec;
                  len_in    = len_ff + LEN_W'(1);
               end
            end
            olid_pkg::MODE_APPEND: begin
               if (full) begin
                  status_in = olid_pkg::ST_FULL;
               end else begin
                  mem_we = 1'b1;
                  len_in = len_ff + LEN_W'(1);
               end
            end
            default: begin
               // delete: drop the front by moving the head, the back by
               // shortening, anything between by compaction
               if (range_err) begin
                  status_in = olid_pkg::ST_RANGE;
               end else if (pos_ff == '0) begin
                  head_in = head_inc;
                  len_in  = len_dec;
               end else if (at_back) begin
                  len_in = len_dec;
               end else begin
                  cur_in = LEN_W'(pos_ff);
               end
            end
         endcase
      end
      if (cmd.shift_wr) begin
         mem_we    = 1'b1;
         mem_waddr = phys(head_ff, cur_ff);
         mem_wdata = shift_data_ff;
         if (stat.shift_end) begin
            cur_in = '0;
            len_in = len_dec;
         end else begin
            cur_in = cur_p1;
         end
      end
      if (cmd.list_issue) begin
         cur_in = cur_p1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         len_ff     <= '0;
         cur_ff     <= '0;
         status_ff  <= olid_pkg::ST_DONE;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         len_ff    <= len_in;
         cur_ff    <= cur_in;
         status_ff <= status_in;
         if (cmd.list_issue) begin
            a_valid_ff <= 1'b1;
         end else if (a_move) begin
            a_valid_ff <= 1'b0;
         end
         if (a_move) begin
            b_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            b_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      if (cmd.shift_rd) begin
         shift_data_ff <= mem[rd_addr];
      end
      if (cmd.list_issue) begin
         a_data_ff   <= mem[rd_addr];
         a_index_ff  <= olid_pkg::INDEX_W'(cur_ff);
         a_last_ff   <= stat.list_end;
         a_empty_ff  <= (len_ff == '0);
         a_status_ff <= status_ff;
      end
      if (a_move) begin
         // an empty listing carries a zero value whatever the store holds
         b_value_ff  <= a_empty_ff ? '0 : a_data_ff;
         b_index_ff  <= a_index_ff;
         b_last_ff   <= a_last_ff;
         b_empty_ff  <= a_empty_ff;
         b_status_ff <= a_status_ff;
      end
   end

   assign rsp_valid         = b_valid_ff;
   assign rsp_status        = b_status_ff;
   assign rsp_list_empty    = b_empty_ff;
   assign rsp_element_value = b_value_ff;
   assign rsp_element_index = b_index_ff;
   assign rsp_last          = b_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(CAPACITY))
      else $error("list length beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      cmd.update && is_ins && !full |=> len_ff == $past(len_ff) + LEN_W'(1))
      else $error("insert did not grow the list");

   assert property (@(posedge clock) disable iff (reset)
      cmd.list_issue |-> (!a_valid_ff || a_move) && !mem_we)
      else $error("listing read overruns stage or collides with a store write");

   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_empty_ff |-> b_last_ff && (b_value_ff == '0))
      else $error("empty listing not a single zero result");

endmodule

FILE: rtl/ordered_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Ordered list with insert, append and delete
// Keeps up to CAPACITY signed 32-bit values and lists them after every
// operation.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one operation per transaction (mode, value, position).
//   rsp_ch returns the whole list front to back, one element per transaction,
//   with last set on the final one; an empty list gives one result with
//   list_empty set. Every result of an operation carries its status.
//   One operation is in work at a time: req_ch.ready is high only while idle.
//   Each operation is captured, then updated, then listed with one store read
//   per listed element (at least one).
//   A delete strictly inside the list adds one store read and one store write
//   per element moved up (length - position - 1 moves).
//   The first result passes the update, the listing read and both output stages.
//   The next operation is accepted as soon as the last read of a listing is
//   issued; results already read wait in a two-deep output pipeline.
//   When rsp_ch stalls, the listing halts and resumes without loss.
//   Reset empties the list; the store itself is not cleared.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete #(
   parameter int CAPACITY = 16
) (
   input  logic      clock,
   input  logic      reset,
   olid_req_if.sink   req_ch,
   olid_rsp_if.source rsp_ch
);

   olid_pkg::ctl_cmd_type cmd;
   olid_pkg::dp_stat_type stat;

   olid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   olid_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_mode          (req_ch.mode),
      .req_value         (req_ch.value),
      .req_position      (req_ch.position),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_status        (rsp_ch.status),
      .rsp_list_empty    (rsp_ch.list_empty),
      .rsp_element_value (rsp_ch.element_value),
      .rsp_element_index (rsp_ch.element_index),
      .rsp_last          (rsp_ch.last)
   );

endmodule
